// ----- hw/rtl/mlfnv_pkg.sv -----
// Package for the multi-lane FNV hash: lane seeds, lane primes and the lane update function.
package mlfnv_pkg;

	localparam int unsigned LANE_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DIG_LO_W  = 64;
	localparam int unsigned DIG_HI_W  = 56;
	localparam int unsigned H3_KEEP_W = DIG_HI_W - LANE_W;

	typedef logic [LANE_W-1:0] lane_t;

	localparam lane_t SEED_ZERO  = 32'h811C9DC5;
	localparam lane_t SEED_ONE   = 32'hA1B2C3D4;
	localparam lane_t SEED_TWO   = 32'h9E3779B9;
	localparam lane_t SEED_THREE = 32'hC2B2AE35;
	localparam lane_t SEED_FOUR  = 32'h165667B1;

	localparam lane_t MUL_A = 32'd16777619;
	localparam lane_t MUL_B = 32'd2166136261;
	localparam lane_t MUL_C = 32'd1099511627;

	localparam int unsigned ROT_ONE   = 5;
	localparam int unsigned ROT_THREE = 7;

	// xor byte, optional left rotate, multiply mod 2^32
	function automatic lane_t lane_step(lane_t h, logic [BYTE_W-1:0] c,
			int unsigned rot, lane_t mul);
		lane_t x;
		lane_t r;
		x = h ^ {{(LANE_W-BYTE_W){1'b0}}, c};
		r = (rot == 0) ? x : ((x << rot) | (x >> (LANE_W - rot)));
		return r * mul;
	endfunction

endpackage

// ----- hw/rtl/multi_lane_fnv_hash_120_top.sv -----
// Multi-lane FNV hash: input register, five lane registers and a digest output register.
//
// Input channel: data_byte, no_byte and last with byte_valid/byte_stall. An item is
// taken at a clock edge with byte_valid high and byte_stall low. Each item with
// no_byte low is folded into all five 32-bit lanes. An item with last high ends the
// message and produces one digest; the lanes then go back to their seeds, so the
// next item starts a new message. An item with both no_byte and last high closes a
// message without adding a byte (empty message when it comes first).
// Output channel: digest_low and digest_high with digest_valid/digest_stall.
// Path: a last item goes from the input register to the digest register, which drives the ports.
// Throughput: one item per cycle, set by the per-lane constant multiply in the lane
// feedback loop. The input register keeps taking items while a digest waits; a last
// item that finds the digest register full and stalled holds in the input register
// and byte_stall rises until the digest is taken.
// Reset: arst_n low empties both registers and loads the lane seeds.
module multi_lane_fnv_hash_120_top
	import mlfnv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                no_byte,
	input  logic                last,
	input  logic                byte_valid,
	output logic                byte_stall,
	output logic [DIG_LO_W-1:0] digest_low,
	output logic [DIG_HI_W-1:0] digest_high,
	output logic                digest_valid,
	input  logic                digest_stall
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              no_byte_s1;
	logic              last_s1;

	lane_t lane_zero_q, lane_one_q, lane_two_q, lane_three_q, lane_four_q;
	lane_t nxt_zero, nxt_one, nxt_two, nxt_three, nxt_four;
	lane_t h0, h1, h2, h3;

	logic out_free;
	logic advance;
	logic take_in;

	assign out_free   = !digest_valid || !digest_stall;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign take_in    = byte_valid && !byte_stall;

	always_comb begin
		if (no_byte_s1) begin
			nxt_zero  = lane_zero_q;
			nxt_one   = lane_one_q;
			nxt_two   = lane_two_q;
			nxt_three = lane_three_q;
			nxt_four  = lane_four_q;
		end else begin
			nxt_zero  = lane_step(lane_zero_q,  byte_s1, 0,         MUL_A);
			nxt_one   = lane_step(lane_one_q,   byte_s1, ROT_ONE,   MUL_B);
			nxt_two   = lane_step(lane_two_q,   byte_s1, 0,         MUL_C);
			nxt_three = lane_step(lane_three_q, byte_s1, ROT_THREE, MUL_A);
			nxt_four  = lane_step(lane_four_q,  byte_s1, 0,         MUL_B);
		end
		// avalanche in order; nxt_four has no word of its own and only feeds h0 and h3
		h0 = nxt_zero ^ nxt_one ^ nxt_two ^ nxt_three ^ nxt_four;
		h1 = nxt_one ^ h0;
		h2 = nxt_two ^ nxt_three;
		h3 = nxt_three ^ nxt_four;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1    <= data_byte;
			no_byte_s1 <= no_byte;
			last_s1    <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_zero_q  <= SEED_ZERO;
			lane_one_q   <= SEED_ONE;
			lane_two_q   <= SEED_TWO;
			lane_three_q <= SEED_THREE;
			lane_four_q  <= SEED_FOUR;
		end else if (advance) begin
			if (last_s1) begin
				lane_zero_q  <= SEED_ZERO;
				lane_one_q   <= SEED_ONE;
				lane_two_q   <= SEED_TWO;
				lane_three_q <= SEED_THREE;
				lane_four_q  <= SEED_FOUR;
			end else begin
				lane_zero_q  <= nxt_zero;
				lane_one_q   <= nxt_one;
				lane_two_q   <= nxt_two;
				lane_three_q <= nxt_three;
				lane_four_q  <= nxt_four;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_valid <= 1'b0;
		end else if (advance && last_s1) begin
			digest_valid <= 1'b1;
		end else if (!digest_stall) begin
			digest_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			digest_low  <= {h1, h0};
			digest_high <= {h3[H3_KEEP_W-1:0], h2};
		end
	end

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> valid_s1)
		else $error("accepted item did not land in the input register");

	a_last_reseeds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> lane_zero_q == SEED_ZERO && lane_one_q == SEED_ONE &&
			lane_two_q == SEED_TWO && lane_three_q == SEED_THREE &&
			lane_four_q == SEED_FOUR)
		else $error("lanes not reseeded after a digest");

	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && no_byte_s1 |=> lane_zero_q == $past(lane_zero_q) &&
			lane_four_q == $past(lane_four_q))
		else $error("empty item changed the lanes");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |-> !(advance && last_s1))
		else $error("digest overwritten while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && last_s1 && digest_valid && digest_stall)
		else $error("input stalled without a blocked digest");

endmodule
